// ----- design/sit_pkg.sv -----
// Shared types and codes for the sorted insert table.
// No dependencies.
`timescale 1ns / 1ps

package sit_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_CHANGE = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] position;
        logic [4:0] entry_count;
    } result_t;

endpackage

// ----- design/sit_mem.sv -----
// Entry store: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sit_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                aclk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  logic signed [31:0]  wdata,
    input  logic                re,
    input  logic [AW-1:0]       raddr,
    output logic signed [31:0]  rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sit_ctrl.sv -----
// Sequencer: walks the entry store for insert, find and change.
// Depends on sit_pkg; drives sit_mem.
`timescale 1ns / 1ps

module sit_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_op,
    input  logic signed [31:0]  in_value,
    input  logic signed [31:0]  in_new_value,
    output logic                res_valid,
    input  logic                res_ready,
    output sit_pkg::result_t    res,
    output logic                mem_we,
    output logic [AW-1:0]       mem_waddr,
    output logic signed [31:0]  mem_wdata,
    output logic                mem_re,
    output logic [AW-1:0]       mem_raddr,
    input  logic signed [31:0]  mem_rdata
);
    import sit_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [1:0]         op_reg, op_next;
    logic signed [31:0] val_reg, val_next;
    logic signed [31:0] nval_reg, nval_next;
    logic signed [31:0] carry_reg, carry_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      hit_reg, hit_next;
    logic               found_reg, found_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic [1:0]         status_reg, status_next;
    logic [AW-1:0]      pos_reg, pos_next;

    logic [CW-1:0]      idx_ext;
    logic               at_end;
    logic               is_hit;
    logic [AW+3:0]      pos_wide;
    logic [CW+4:0]      cnt_wide;

    assign idx_ext = CW'(idx_reg);
    assign at_end  = (idx_ext == fill_reg);
    assign is_hit  = (mem_rdata == val_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
        op_reg     <= op_next;
        val_reg    <= val_next;
        nval_reg   <= nval_next;
        carry_reg  <= carry_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        nval_next   = nval_reg;
        carry_next  = carry_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        fill_next   = fill_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg;
        mem_wdata   = val_reg;
        mem_re      = 1'b0;
        mem_raddr   = idx_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next     = in_op;
                    val_next    = in_value;
                    nval_next   = in_new_value;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = ST_DONE;
                    pos_next    = '0;
                    priority if (in_op == OP_INSERT) begin
                        if (fill_reg == CW'(DEPTH)) begin
                            status_next = ST_FULL;
                            state_next  = S_OUT;
                        end else begin
                            state_next = S_RD;
                        end
                    end else if (in_op == OP_FIND || in_op == OP_CHANGE) begin
                        if (fill_reg == '0) begin
                            status_next = ST_NOTFOUND;
                            state_next  = S_OUT;
                        end else begin
                            state_next = S_RD;
                        end
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_RD: begin
                mem_re     = !at_end;
                state_next = S_EV;
            end
            S_EV: begin
                if (op_reg == OP_INSERT) begin
                    if (at_end) begin
                        // tail slot takes the displaced entry or the new value
                        mem_we     = 1'b1;
                        mem_wdata  = found_reg ? carry_reg : val_reg;
                        pos_next   = found_reg ? hit_reg : idx_reg;
                        fill_next  = fill_reg + CW'(1);
                        state_next = S_OUT;
                    end else begin
                        if (found_reg) begin
                            mem_we     = 1'b1;
                            mem_wdata  = carry_reg;
                            carry_next = mem_rdata;
                        end else if (mem_rdata > val_reg) begin
                            mem_we     = 1'b1;
                            mem_wdata  = val_reg;
                            carry_next = mem_rdata;
                            found_next = 1'b1;
                            hit_next   = idx_reg;
                        end
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RD;
                    end
                end else begin
                    if (is_hit) begin
                        found_next = 1'b1;
                        hit_next   = idx_reg;
                    end
                    if (idx_ext == fill_reg - CW'(1)) begin
                        if (is_hit || found_reg) begin
                            pos_next  = is_hit ? idx_reg : hit_reg;
                            mem_we    = (op_reg == OP_CHANGE);
                            mem_waddr = is_hit ? idx_reg : hit_reg;
                            mem_wdata = nval_reg;
                        end else begin
                            status_next = ST_NOTFOUND;
                        end
                        state_next = S_OUT;
                    end else begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_RD;
                    end
                end
            end
            S_OUT: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign pos_wide = {4'b0000, pos_reg};
    assign cnt_wide = {5'b00000, fill_reg};

    assign in_ready         = (state_reg == S_IDLE);
    assign res_valid        = (state_reg == S_OUT);
    assign res.status       = status_reg;
    assign res.position     = pos_wide[3:0];
    assign res.entry_count  = cnt_wide[4:0];

endmodule

// ----- design/sorted_insert_table.sv -----
// Top level of the sorted insert table: sequencer, entry store, result register.
// Depends on sit_pkg, sit_mem and sit_ctrl.
`timescale 1ns / 1ps
//
//  channel | dir | tdata                          | tuser
//  --------+-----+--------------------------------+-------------
//  s_      | in  | value[31:0], new_value[63:32]  | opcode[1:0]
//  m_      | out | position[3:0], entry_count[8:4] | status[1:0]
//
//  One beat at a time. The sequencer reads the store once per entry and
//  evaluates on the next cycle; full insert, empty find or change and unused
//  opcodes skip the walk and go straight to the result. Reset clears the fill
//  count and the state, not the store; no clearing pass.
//  A result waiting in the output register does not block the next s_ beat.

module sorted_insert_table #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value, new_value
    input  logic [1:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // position, entry_count, zero pad
    output logic [1:0]  m_tuser    // status
);
    import sit_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic signed [31:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;
    logic signed [31:0] mem_rdata;

    logic               res_valid;
    logic               res_ready;
    result_t            res;

    logic               m_valid_reg;
    result_t            m_res_reg;

    sit_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sit_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_op        (s_tuser),
        .in_value     (s_tdata[31:0]),
        .in_new_value (s_tdata[63:32]),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0000000, m_res_reg.entry_count, m_res_reg.position};
    assign m_tuser  = m_res_reg.status;

endmodule
